### sv/first_touch_shuffled_page_map_assert.svh
// Assertion macros used by the checker of the page map.
`ifndef FIRST_TOUCH_SHUFFLED_PAGE_MAP_ASSERT_SVH
`define FIRST_TOUCH_SHUFFLED_PAGE_MAP_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define FTSPM_ASSERT_NOW(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("page map check failed");

// Condition holds in the cycle after the trigger.
`define FTSPM_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("page map check failed");

`endif

### sv/ftspm_pkg.sv
`default_nettype none

package ftspm_pkg;

   localparam int VPAGE_ENTRIES_DEF = 4096;
   localparam int ADDR_BITS         = 48;

   localparam int VA_W    = 48;
   localparam int FRAME_W = 36;
   localparam int SHIFT_W = 5;
   localparam int FBITS_W = 6;
   localparam int COUNT_W = 64;

   localparam logic [COUNT_W-1:0] MIX_MUL     = 64'h9E37_79B9_7F4A_7C15;
   localparam int                 MIX_SHIFT_A = 7;
   localparam int                 MIX_SHIFT_B = 11;

   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;
   localparam logic [FBITS_W-1:0] FRAME_BITS_RESET = 6'd20;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_SHIFT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_BITS = 4'd1;

   // Physical addresses keep only the bits below ADDR_BITS.
   localparam logic [VA_W-1:0] ADDR_MASK = (ADDR_BITS >= VA_W) ? {VA_W{1'b1}} :
                                           VA_W'((64'd1 << ADDR_BITS) - 64'd1);

   typedef struct packed {
      logic [VA_W-1:0] phys_addr;
      logic            out_of_range;
      logic            newly_mapped;
   } result_type;

   // The offset is below the page size, so placing the frame above it is an OR.
   function automatic logic [VA_W-1:0] make_phys(input logic [FRAME_W-1:0] frame,
                                                 input logic [SHIFT_W-1:0] shift,
                                                 input logic [VA_W-1:0]    offset);
      logic [VA_W-1:0] placed;
      placed = VA_W'(frame) << shift;
      return (placed | offset) & ADDR_MASK;
   endfunction

endpackage

`default_nettype wire

### sv/ftspm_ram.sv
`default_nettype none

module ftspm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/ftspm_mix.sv
`default_nettype none

module ftspm_mix
   import ftspm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [COUNT_W-1:0] count,
   input  wire logic [FBITS_W-1:0] frame_bits,
   output logic                    done,
   output logic      [FRAME_W-1:0] frame
);

   typedef enum logic [4:0] {
      MX_IDLE = 5'b00001,
      MX_MUL0 = 5'b00010,
      MX_MUL1 = 5'b00100,
      MX_MUL2 = 5'b01000,
      MX_FIN  = 5'b10000
   } mix_state_type;

   localparam logic [31:0] MUL_LO = MIX_MUL[31:0];
   localparam logic [31:0] MUL_HI = MIX_MUL[63:32];

   mix_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] x_ff, x_in;
   logic [COUNT_W-1:0] prod_ff, prod_in;
   logic [31:0]        op_a, op_b;
   logic [63:0]        mul_out;
   logic [COUNT_W-1:0] folded;
   logic [FBITS_W-1:0] used_bits;
   logic [FRAME_W-1:0] mask;

   // One 32x32 multiplier builds the low 64 bits of the product from three partial products in turn:
   // the full low partial product, then the low halves of the two cross terms.
   always_comb begin
      op_a = x_ff[31:0];
      op_b = MUL_LO;
      unique case (state_ff)
         MX_MUL1: op_a = x_ff[63:32];
         MX_MUL2: op_b = MUL_HI;
         default: ;
      endcase
   end

   assign mul_out = {32'd0, op_a} * {32'd0, op_b};

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      prod_in  = prod_ff;
      unique case (state_ff)
         MX_IDLE: begin
            if (start) begin
               x_in     = count ^ (count >> MIX_SHIFT_A);
               state_in = MX_MUL0;
            end
         end
         MX_MUL0: begin
            prod_in  = mul_out;
            state_in = MX_MUL1;
         end
         MX_MUL1: begin
            prod_in[63:32] = prod_ff[63:32] + mul_out[31:0];
            state_in       = MX_MUL2;
         end
         MX_MUL2: begin
            prod_in[63:32] = prod_ff[63:32] + mul_out[31:0];
            state_in       = MX_FIN;
         end
         MX_FIN: begin
            state_in = MX_IDLE;
         end
         default: state_in = MX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MX_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      prod_ff <= prod_in;
   end

   assign folded    = prod_ff ^ (prod_ff >> MIX_SHIFT_B);
   assign used_bits = (frame_bits > FBITS_W'(FRAME_W)) ? FBITS_W'(FRAME_W) : frame_bits;
   assign mask      = ~({FRAME_W{1'b1}} << used_bits);

   assign done  = (state_ff == MX_FIN);
   assign frame = folded[FRAME_W-1:0] & mask;

endmodule

`default_nettype wire

### sv/first_touch_shuffled_page_map.sv
// Translates one virtual byte address per beat into a physical byte address, allocating a
// frame the first time a page is touched. The page table lives in one RAM that holds a
// valid bit and a frame per virtual page. After reset the block sweeps every entry of that
// RAM, one entry a cycle, before it takes its first request; CSR writes are taken at all
// times. A request whose page hits the table, or lies beyond it, is answered from the
// registered table read. A miss waits for the frame mixer, which shares one 32x32
// multiplier over three partial products; the block then writes the new entry back. No new
// request is taken until the current one has its response. A finished response waits in an
// output register and, if that is still occupied, in one holding register, so the next
// request can be taken while an earlier response is stalled. rsp_tuser bit 0 flags a new
// allocation and bit 1 flags a page beyond the table, for which the address reads as zero.
`default_nettype none

module first_touch_shuffled_page_map
   import ftspm_pkg::*;
#(
   parameter int VPAGE_ENTRIES = VPAGE_ENTRIES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [VA_W-1:0]        req_tdata,   // virt_addr
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [VA_W-1:0]        rsp_tdata,   // phys_addr
   output logic      [1:0]             rsp_tuser,   // out_of_range, newly_mapped
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int                IDX_W     = $clog2(VPAGE_ENTRIES);
   localparam int                ENTRY_W   = FRAME_W + 1;
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(VPAGE_ENTRIES - 1);
   localparam logic [VA_W-1:0]   ENTRIES_VA = VA_W'(VPAGE_ENTRIES);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_LOOK  = 4'b0100,
      ST_MIX   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [VA_W-1:0]    va_ff, va_in;
   logic [SHIFT_W-1:0] page_shift_ff, page_shift_in;
   logic [FBITS_W-1:0] frame_bits_ff, frame_bits_in;
   logic [COUNT_W-1:0] alloc_ff, alloc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               pend_ff, pend_in;
   result_type         pend_res_ff, pend_res_in;

   logic               req_accept;
   logic               rsp_free;
   logic [VA_W-1:0]    req_vpage;
   logic [VA_W-1:0]    vpage;
   logic [VA_W-1:0]    offset;
   logic               in_range;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;

   logic               mix_start;
   logic               mix_done;
   logic [FRAME_W-1:0] mix_frame;

   logic               res_fire;
   result_type         res;

   assign req_tready = (state_ff == ST_IDLE) && !pend_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign req_vpage = req_tdata >> page_shift_ff;
   assign vpage     = va_ff >> page_shift_ff;
   assign offset    = va_ff & ~({VA_W{1'b1}} << page_shift_ff);
   assign in_range  = (vpage < ENTRIES_VA);

   ftspm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (VPAGE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_vpage[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   ftspm_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .start      (mix_start),
      .count      (alloc_ff),
      .frame_bits (frame_bits_ff),
      .done       (mix_done),
      .frame      (mix_frame)
   );

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      va_in     = va_ff;
      alloc_in  = alloc_ff;
      ram_we    = 1'b0;
      ram_waddr = vpage[IDX_W-1:0];
      ram_wdata = {1'b1, mix_frame};
      mix_start = 1'b0;
      res_fire  = 1'b0;
      res       = '{phys_addr: '0, out_of_range: 1'b0, newly_mapped: 1'b0};

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               va_in    = req_tdata;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (!in_range) begin
               res_fire         = 1'b1;
               res.out_of_range = 1'b1;
               state_in         = ST_IDLE;
            end else if (ram_rdata[FRAME_W]) begin
               res_fire      = 1'b1;
               res.phys_addr = make_phys(ram_rdata[FRAME_W-1:0], page_shift_ff, offset);
               state_in      = ST_IDLE;
            end else begin
               mix_start = 1'b1;
               state_in  = ST_MIX;
            end
         end
         ST_MIX: begin
            if (mix_done) begin
               ram_we           = 1'b1;
               alloc_in         = alloc_ff + COUNT_W'(1);
               res_fire         = 1'b1;
               res.newly_mapped = 1'b1;
               res.phys_addr    = make_phys(mix_frame, page_shift_ff, offset);
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // A new response goes straight to the output register when it is free, otherwise it
   // parks in the holding register, which blocks further requests until it drains.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      pend_res_in  = pend_res_ff;
      if (res_fire) begin
         if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res;
         end else begin
            pend_in     = 1'b1;
            pend_res_in = res;
         end
      end else if (pend_ff && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = pend_res_ff;
         pend_in      = 1'b0;
      end
   end

   always_comb begin
      page_shift_in = page_shift_ff;
      frame_bits_in = frame_bits_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PAGE_SHIFT: page_shift_in = csr_data[SHIFT_W-1:0];
            CSR_FRAME_BITS: frame_bits_in = csr_data[FBITS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         page_shift_ff <= PAGE_SHIFT_RESET;
         frame_bits_ff <= FRAME_BITS_RESET;
         alloc_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         page_shift_ff <= page_shift_in;
         frame_bits_ff <= frame_bits_in;
         alloc_ff      <= alloc_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
      end
      va_ff       <= va_in;
      rsp_ff      <= rsp_in;
      pend_res_ff <= pend_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.phys_addr;
   assign rsp_tuser  = {rsp_ff.out_of_range, rsp_ff.newly_mapped};

endmodule

`default_nettype wire

### sv/ftspm_checker.sv
`default_nettype none
`include "first_touch_shuffled_page_map_assert.svh"

module ftspm_checker
   import ftspm_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [VA_W-1:0]        req_tdata,   // virt_addr
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [VA_W-1:0]        rsp_tdata,   // phys_addr
   input wire logic [1:0]             rsp_tuser,   // out_of_range, newly_mapped
   input wire logic                   csr_valid,
   input wire logic                   csr_ready,
   input wire logic [CSR_INDEX_W-1:0] csr_index,
   input wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic unused_inputs;
   assign unused_inputs = ^{req_tdata, csr_valid, csr_ready, csr_index, csr_data};

   // A page beyond the table never allocates and reads as address zero.
   `FTSPM_ASSERT_NOW(a_range_zero, rsp_tvalid && rsp_tuser[1], (rsp_tdata == '0) && !rsp_tuser[0])

   // After a request is taken the block leaves its idle state, so requests are never taken in back-to-back cycles.
   `FTSPM_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready)

   // The clearing sweep holds off requests and responses right after reset.
   `FTSPM_ASSERT_NEXT(a_sweep_after_reset, $fell(reset), !req_tready && !rsp_tvalid)

   // A stalled response beat keeps its contents.
   `FTSPM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind first_touch_shuffled_page_map ftspm_checker u_checker (.*);

`default_nettype wire
